FILE: sv/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared types, widths and the microcode table of the Fibonacci matrix
// power block.
// ----------------------------------------------------------------------------
package fmp_pkg;

    localparam int unsigned IDX_W  = 31;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(IDX_W);
    localparam int unsigned PC_W   = 2;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_INIT = 2'd0;
    localparam pc_t PC_MUL  = 2'd1;
    localparam pc_t PC_UPD  = 2'd2;
    localparam pc_t PC_OUT  = 2'd3;

    // Branch conditions of a control word
    typedef enum logic [2:0] {
        COND_NEXT = 3'd0,   // advance to the following step
        COND_JUMP = 3'd1,   // always branch
        COND_ZERO = 3'd2,   // branch when the index is zero
        COND_MORE = 3'd3,   // branch while exponent bits remain
        COND_HOLD = 3'd4    // stay while the result register is occupied
    } cond_t;

    // Datapath strobes
    typedef struct packed {
        logic init;
        logic mul;
        logic upd;
        logic out_load;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic n_zero;
        logic last_bit;
    } dp_status_t;

    typedef struct packed {
        ctrl_t ops;
        cond_t cond;
        pc_t   target;
        logic  last;
    } ucode_t;

    function automatic ucode_t ucode_fetch(input pc_t pc);
        ucode_t w;
        w = '0;
        w.cond = COND_NEXT;
        case (pc)
            PC_INIT:
            begin
                w.ops.init = 1'b1;
                w.cond     = COND_ZERO;
                w.target   = PC_OUT;
            end
            PC_MUL:
            begin
                w.ops.mul = 1'b1;
                w.cond    = COND_NEXT;
                w.target  = PC_UPD;
            end
            PC_UPD:
            begin
                w.ops.upd = 1'b1;
                w.cond    = COND_MORE;
                w.target  = PC_MUL;
            end
            PC_OUT:
            begin
                w.ops.out_load = 1'b1;
                w.cond         = COND_HOLD;
                w.target       = PC_OUT;
                w.last         = 1'b1;
            end
            default:
            begin
                w = '0;
                w.cond = COND_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: sv/fibonacci_matrix_power.sv
// ----------------------------------------------------------------------------
// fibonacci_matrix_power
// A non-zero index runs one set-up step, a multiply and an update step per
// exponent bit over 31 bits, and one output step; index zero goes from the
// set-up step straight to the output step. A new index is taken only once the
// previous result has been loaded into the output register, and the output
// step waits while an earlier result has not yet been taken.
// Reset clears the sequencer and the result valid flag; data registers keep.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic        [fmp_pkg::IDX_W-1:0]  index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fmp_pkg::DATA_W-1:0] fib_value
);
    import fmp_pkg::*;

    ctrl_t             ctrl;
    dp_status_t        status;
    logic              busy;
    logic              in_fire;
    logic              out_blocked;
    logic [DATA_W-1:0] result;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] fib_value_reg;

    assign in_ready    = !busy;
    assign in_fire     = in_valid && in_ready;
    assign out_blocked = out_valid_reg && !out_ready;

    fmp_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_fire),
        .status      (status),
        .out_blocked (out_blocked),
        .ctrl        (ctrl),
        .busy        (busy)
    );

    fmp_datapath u_dp (
        .clk      (clk),
        .load_idx (in_fire),
        .index    (index),
        .ctrl     (ctrl),
        .status   (status),
        .result   (result)
    );

    // Output register: load on the final step, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
            fib_value_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign fib_value = fib_value_reg;

endmodule

FILE: sv/fmp_seq.sv
// ----------------------------------------------------------------------------
// fmp_seq
// Microcode sequencer: step counter, control ROM and branch logic.
// ----------------------------------------------------------------------------
module fmp_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fmp_pkg::dp_status_t status,
    input  logic                out_blocked,
    output fmp_pkg::ctrl_t      ctrl,
    output logic                busy
);
    import fmp_pkg::*;

    logic   busy_reg;
    logic   busy_next;
    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t word;
    logic   take;
    logic   hold;

    always_comb
    begin
        word = ucode_fetch(pc_reg);
        case (word.cond)
            COND_JUMP: take = 1'b1;
            COND_ZERO: take = status.n_zero;
            COND_MORE: take = !status.last_bit;
            default:   take = 1'b0;
        endcase
        hold = (word.cond == COND_HOLD) && out_blocked;

        ctrl = '0;
        if (busy_reg)
        begin
            ctrl          = word.ops;
            ctrl.out_load = word.ops.out_load && !hold;
        end

        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                pc_next   = PC_INIT;
            end
        end
        else if (!hold)
        begin
            if (word.last)
                busy_next = 1'b0;
            else if (take)
                pc_next = word.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_INIT;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: sv/fmp_datapath.sv
// ----------------------------------------------------------------------------
// fmp_datapath
// Matrix power datapath. The working power of [[1,1],[1,0]] is kept as
// a = F(k+1), b = F(k); the lower-right entry is a - b.
// ----------------------------------------------------------------------------
module fmp_datapath (
    input  logic                       clk,
    input  logic                       load_idx,
    input  logic [fmp_pkg::IDX_W-1:0]  index,
    input  fmp_pkg::ctrl_t             ctrl,
    output fmp_pkg::dp_status_t        status,
    output logic [fmp_pkg::DATA_W-1:0] result
);
    import fmp_pkg::*;

    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  exp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [DATA_W-1:0] paa_reg;
    logic [DATA_W-1:0] pbb_reg;
    logic [DATA_W-1:0] pbx_reg;
    logic [DATA_W-1:0] a_next;
    logic [DATA_W-1:0] b_next;
    logic [DATA_W-1:0] twoa_b;
    logic [DATA_W-1:0] sq_a;
    logic [DATA_W-1:0] sq_b;

    // Squaring: a' = a*a + b*b, b' = b*(2a - b)
    assign twoa_b = {a_reg[DATA_W-2:0], 1'b0} - b_reg;
    assign sq_a   = paa_reg + pbb_reg;
    assign sq_b   = pbx_reg;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (ctrl.init)
        begin
            a_next = DATA_W'(1);
            b_next = '0;
        end
        else if (ctrl.upd)
        begin
            // set bit: multiply by the base matrix as well
            if (exp_reg[cnt_reg])
            begin
                a_next = sq_a + sq_b;
                b_next = sq_a;
            end
            else
            begin
                a_next = sq_a;
                b_next = sq_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_idx)
            index_reg <= index;
        if (ctrl.init)
        begin
            exp_reg <= index_reg - 1'b1;
            cnt_reg <= CNT_W'(IDX_W - 1);
        end
        else if (ctrl.upd)
            cnt_reg <= cnt_reg - 1'b1;
        if (ctrl.mul)
        begin
            paa_reg <= a_reg * a_reg;
            pbb_reg <= b_reg * b_reg;
            pbx_reg <= b_reg * twoa_b;
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign status.n_zero   = (index_reg == '0);
    assign status.last_bit = (cnt_reg == '0);
    assign result          = status.n_zero ? '0 : a_reg;

endmodule

FILE: sv/fmp_checker.sv
// ----------------------------------------------------------------------------
// fmp_checker
// Port-level checks on the Fibonacci matrix power block, bound to the top.
// ----------------------------------------------------------------------------
module fmp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [fmp_pkg::DATA_W-1:0] fib_value
);
    import fmp_pkg::*;

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fib_value))
        else $error("result changed or vanished before being taken");

    // One transaction in flight: input closes once an index is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still open after an index was accepted");

    // No result can appear in the cycle after an index is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A fresh result means the sequence has finished and input reopens
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result posted while the sequence is still running");

endmodule

bind fibonacci_matrix_power fmp_checker u_fmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fib_value (fib_value)
);

FILE: test/fib_result_checker.sv
// ----------------------------------------------------------------------------
// fib_result_checker
// Watches the index and result channels of the Fibonacci matrix power block,
// predicts F(n) modulo 2^32 for every accepted index and compares each result
// in order against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module fib_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic        [fmp_pkg::IDX_W-1:0]  index,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [fmp_pkg::DATA_W-1:0] fib_value,
    output int                                mismatches,
    output int                                outstanding,
    output int                                results_checked
);
    import fmp_pkg::*;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        word_t a00;
        word_t a01;
        word_t a10;
        word_t a11;
    } mat2_t;

    localparam mat2_t FIB_BASE = '{a00: 32'd1, a01: 32'd1, a10: 32'd1, a11: 32'd0};
    localparam mat2_t IDENTITY = '{a00: 32'd1, a01: 32'd0, a10: 32'd0, a11: 32'd1};
    localparam int    REPORT_MAX = 10;

    logic signed [DATA_W-1:0] expected_fib_q [$];
    logic signed [DATA_W-1:0] fib_due;
    int                       fail_n    = 0;
    int                       checked_n = 0;

    // 2x2 product, every sum and product wrapping at 32 bits
    function automatic mat2_t mat_product(input mat2_t x, input mat2_t y);
        mat2_t r;
        r.a00 = x.a00 * y.a00 + x.a01 * y.a10;
        r.a01 = x.a00 * y.a01 + x.a01 * y.a11;
        r.a10 = x.a10 * y.a00 + x.a11 * y.a10;
        r.a11 = x.a10 * y.a01 + x.a11 * y.a11;
        return r;
    endfunction

    // Raise the base matrix to n-1, scanning all exponent bits from the top
    function automatic logic signed [DATA_W-1:0] fib_of_index(input logic [IDX_W-1:0] n);
        mat2_t            acc;
        logic [IDX_W-1:0] e;
        acc = IDENTITY;
        if (n == '0)
            return '0;
        e = n - 1'b1;
        for (int b = IDX_W - 1; b >= 0; b--)
        begin
            acc = mat_product(acc, acc);
            if (e[b])
                acc = mat_product(acc, FIB_BASE);
        end
        return acc.a00;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Retire the result first: a result never belongs to an index
            // accepted at the same edge
            if (out_valid && out_ready)
            begin
                if (expected_fib_q.size() == 0)
                begin
                    fail_n++;
                    if (fail_n <= REPORT_MAX)
                        $display("unexpected result transaction: fib_value %0d", fib_value);
                end
                else
                begin
                    fib_due = expected_fib_q.pop_front();
                    checked_n++;
                    if (fib_value !== fib_due)
                    begin
                        fail_n++;
                        if (fail_n <= REPORT_MAX)
                            $display("fib_value mismatch: expected %0d (%h), got %0d (%h)",
                                     fib_due, fib_due, fib_value, fib_value);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_fib_q.push_back(fib_of_index(index));
        end
        mismatches      <= fail_n;
        outstanding     <= expected_fib_q.size();
        results_checked <= checked_n;
    end

endmodule

FILE: test/fibonacci_matrix_power_tb.sv
// ----------------------------------------------------------------------------
// fibonacci_matrix_power_tb
// Drives indices into the Fibonacci matrix power block: a directed set of
// edge values and wrap-around cases, then random indices of mixed magnitude
// with random idling on both channels and a long back-pressure stretch.
// ----------------------------------------------------------------------------
module fibonacci_matrix_power_tb;
    import fmp_pkg::*;

    localparam int N_DIRECTED   = 20;
    localparam int N_RANDOM     = 1230;
    localparam int N_QUIET      = 150;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 70;
    localparam int IDLE_LIMIT   = 4000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic        [IDX_W-1:0]  index;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] fib_value;

    int mismatches;
    int pending;
    int checked;
    int sent_n      = 0;
    int idle_cycles = 0;
    bit quiet_tail  = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    logic [IDX_W-1:0] directed_idx [N_DIRECTED] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd10,
        31'd46, 31'd47, 31'd48, 31'd93, 31'd94,
        31'h7FFFFFFF, 31'h7FFFFFFE, 31'h40000000, 31'h40000001,
        31'h3FFFFFFF, 31'h2AAAAAAA, 31'h55555555, 31'h00010000
    };

    fibonacci_matrix_power u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fib_value (fib_value)
    );

    fib_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .index           (index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fib_value       (fib_value),
        .mismatches      (mismatches),
        .outstanding     (pending),
        .results_checked (checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hold the index until the block takes it
    task automatic offer_index(input logic [IDX_W-1:0] n);
        in_valid <= 1'b1;
        index    <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_n++;
    endtask

    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Mostly modest widths so that short and long exponents both turn up
    function automatic logic [IDX_W-1:0] random_index();
        logic [IDX_W-1:0] n;
        case ($urandom_range(0, 3))
            0:       n = IDX_W'($urandom_range(0, 100));
            1, 2:    n = IDX_W'($urandom >> (32 - $urandom_range(1, IDX_W)));
            default: n = IDX_W'($urandom);
        endcase
        return n;
    endfunction

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        index    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_idx[i])
        begin
            offer_index(directed_idx[i]);
            sender_gap();
        end

        // Drain completely before the random part
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);

        hold_req <= 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - N_QUIET)
                quiet_tail <= 1'b1;
            offer_index(random_index());
            sender_gap();
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d indices (%0d directed: zero, one, two, wrap-around, all-ones),",
                 sent_n, N_DIRECTED);
        $display("checked %0d results with %0d mismatches, incl. a %0d-cycle output stall",
                 checked, mismatches, LONG_HOLD);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random ready bursts, one long hold-off, none at the tail
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

FILE: filelist.f
sv/fmp_pkg.sv
sv/fmp_seq.sv
sv/fmp_datapath.sv
sv/fibonacci_matrix_power.sv
sv/fmp_checker.sv
test/fib_result_checker.sv
test/fibonacci_matrix_power_tb.sv
